FILE: src/vrli_pkg.sv
// Shared types and constants of the voxel ray line integral block.
package vrli_pkg;

  localparam int GRID_PLANES = 32;
  localparam int GRID_ROWS   = 32;
  localparam int GRID_COLS   = 32;
  localparam int STORE_DEPTH = GRID_PLANES * GRID_ROWS * GRID_COLS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int PL_W        = $clog2(GRID_PLANES);
  localparam int RW_W        = $clog2(GRID_ROWS);
  localparam int CL_W        = $clog2(GRID_COLS);

  localparam int IDX_W  = 35;   // voxel index, signed
  localparam int TDATA_W = 240;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [1:0] REG_SPACING_X = 2'd0;
  localparam logic [1:0] REG_SPACING_Y = 2'd1;
  localparam logic [1:0] REG_SPACING_Z = 2'd2;
  localparam logic [1:0] REG_ROWS      = 2'd3;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_LEFT = 2'd1;
  localparam logic [1:0] STATUS_SAT  = 2'd2;

  localparam logic [33:0] T_ONE  = 34'h1_0000_0000;
  localparam logic [33:0] T_FLAT = 34'h2_0000_0000;
  localparam logic [63:0] ACC_BIAS = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic               is_query;
    logic               wr_ok;
    logic [4:0]         plane;
    logic [4:0]         row;
    logic [4:0]         col;
    logic [31:0]        value;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] sz;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic signed [31:0] ez;
  } item_t;

  typedef struct packed {
    logic [30:0] spacing_x;
    logic [30:0] spacing_y;
    logic [30:0] spacing_z;
    logic [5:0]  rows;
  } cfg_t;

endpackage

FILE: src/vrli_front.sv
// Front end: accept stream words, classify them and queue them for the walker.
module vrli_front
  import vrli_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [TDATA_W-1:0] s_tdata,
  input  logic               s_tuser,
  output logic               q_valid,
  input  logic               q_ready,
  output item_t              q_item
);

  localparam int DEPTH = 4;

  item_t       fifo [DEPTH];
  logic [1:0]  wr_ptr;
  logic [1:0]  rd_ptr;
  logic [2:0]  count;
  item_t       in_item;
  logic        push;
  logic        pop;

  always_comb begin
    in_item.is_query = (s_tuser == CMD_QUERY);
    in_item.plane    = s_tdata[4:0];
    in_item.row      = s_tdata[9:5];
    in_item.col      = s_tdata[14:10];
    in_item.value    = s_tdata[46:15];
    in_item.sx       = s_tdata[78:47];
    in_item.sy       = s_tdata[110:79];
    in_item.sz       = s_tdata[142:111];
    in_item.ex       = s_tdata[174:143];
    in_item.ey       = s_tdata[206:175];
    in_item.ez       = s_tdata[238:207];
    // drop writes that fall outside the grid
    in_item.wr_ok    = (32'(s_tdata[4:0]) < GRID_PLANES) &&
                       (32'(s_tdata[9:5]) < GRID_ROWS) &&
                       (32'(s_tdata[14:10]) < GRID_COLS);
  end

  assign s_tready = (count != 3'(DEPTH));
  assign q_valid  = (count != 3'd0);
  assign q_item   = fifo[rd_ptr];
  assign push     = s_tvalid && s_tready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + 3'(push) - 3'(pop);
    end
  end

endmodule

FILE: src/vrli_walk.sv
// Back end: voxel store, segment setup and the voxel walk with accumulation.
module vrli_walk
  import vrli_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        q_valid,
  output logic        q_ready,
  input  item_t       q_item,
  output logic        res_valid,
  input  logic        res_ready,
  output logic [63:0] res_integral,
  output logic [1:0]  res_status
);

  localparam int KW = 12;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_ROOT, S_RND, S_RND_DIV, S_CHECK, S_CX_MUL, S_CX_NUM,
    S_CX_DIV, S_PICK, S_MUL1, S_MUL2, S_ACC, S_DONE
  } state_t;

  state_t                   state;
  logic [31:0]              mem [STORE_DEPTH];
  logic [31:0]              mem_q;

  logic signed [31:0]       s_r   [3];
  logic signed [32:0]       d_r   [3];
  logic [30:0]              sp_r  [3];
  logic signed [IDX_W-1:0]  idx_r [3];
  logic [33:0]              cr_r  [3];
  logic [1:0]               ax;
  logic [2:0]               need;
  logic [65:0]              sq_sum;
  logic [35:0]              rrem;
  logic [32:0]              root;
  logic [32:0]              len_r;
  logic [5:0]               cnt;
  logic [33:0]              dv_rem;
  logic [33:0]              dv_den;
  logic [33:0]              dv_d;
  logic [33:0]              dv_q;
  logic signed [43:0]       prod_r;
  logic [32:0]              t_r;
  logic [32:0]              dt_r;
  logic [65:0]              p1_r;
  logic [63:0]              m_r;
  logic                     v_pos;
  logic                     v_neg;
  logic [63:0]              acc;
  logic                     sat;
  logic                     left;

  // combinational helpers
  logic [32:0]              dabs;
  logic [34:0]              dv_rs;
  logic                     dv_ge;
  logic [33:0]              dv_rem_next;
  logic [33:0]              dv_q_next;
  logic [35:0]              rt_rem2;
  logic [35:0]              rt_trial;
  logic                     rt_ge;
  logic [32:0]              root_next;
  logic [31:0]              s_mag;
  logic [33:0]              rnd_num;
  logic signed [IDX_W:0]    row_s;
  logic                     in_grid;
  logic [ADDR_W-1:0]        rd_addr;
  logic [ADDR_W-1:0]        wr_addr;
  logic [2:0]               need_rest;
  logic signed [KW-1:0]     kmul;
  logic signed [44:0]       two_s;
  logic signed [44:0]       num;
  logic [1:0]               best;
  logic [33:0]              tn;
  logic [31:0]              vm;
  logic [64:0]              acc_sum;
  logic signed [IDX_W-1:0]  cols_s;
  logic signed [IDX_W-1:0]  planes_s;
  logic signed [IDX_W:0]    rows_s;

  function automatic logic [1:0] first_axis(input logic [2:0] m);
    logic [1:0] r;
    r = 2'd2;
    if (m[1]) r = 2'd1;
    if (m[0]) r = 2'd0;
    return r;
  endfunction

  assign cols_s   = IDX_W'(GRID_COLS);
  assign planes_s = IDX_W'(GRID_PLANES);
  assign rows_s   = (IDX_W + 1)'(GRID_ROWS);

  always_comb begin
    dabs        = d_r[ax][32] ? 33'(-d_r[ax]) : 33'(d_r[ax]);
    dv_rs       = {dv_rem, dv_d[33]};
    dv_ge       = dv_rs >= {1'b0, dv_den};
    dv_rem_next = dv_ge ? 34'(dv_rs - {1'b0, dv_den}) : dv_rs[33:0];
    dv_q_next   = {dv_q[32:0], dv_ge};
    rt_rem2     = {rrem[33:0], sq_sum[65:64]};
    rt_trial    = {1'b0, root, 2'b01};
    rt_ge       = rt_rem2 >= rt_trial;
    root_next   = {root[31:0], rt_ge};
    s_mag       = s_r[ax][31] ? 32'(-33'(s_r[ax])) : 32'(s_r[ax]);
    rnd_num     = {1'b0, s_mag, 1'b0} + 34'(sp_r[ax]);
    row_s       = $signed({{(IDX_W - 5){1'b0}}, cfg.rows}) - (IDX_W + 1)'(1)
                  - (IDX_W + 1)'(idx_r[1]);
    in_grid     = (idx_r[0] >= 0) && (idx_r[0] < cols_s) &&
                  (row_s >= 0) && (row_s < rows_s) &&
                  (idx_r[2] >= 0) && (idx_r[2] < planes_s);
    rd_addr     = ADDR_W'((32'(idx_r[2][PL_W-1:0]) * GRID_ROWS + 32'(row_s[RW_W-1:0]))
                  * GRID_COLS + 32'(idx_r[0][CL_W-1:0]));
    wr_addr     = ADDR_W'((32'(q_item.plane) * GRID_ROWS + 32'(q_item.row))
                  * GRID_COLS + 32'(q_item.col));
    need_rest   = need & ~(3'b001 << ax);
    kmul        = d_r[ax][32] ? ({idx_r[ax][KW-2:0], 1'b0} - KW'(1))
                              : ({idx_r[ax][KW-2:0], 1'b0} + KW'(1));
    two_s       = $signed({{12{s_r[ax][31]}}, s_r[ax], 1'b0});
    num         = d_r[ax][32] ? (two_s - 45'(prod_r)) : (45'(prod_r) - two_s);
    best        = 2'd0;
    if (cr_r[1] <= cr_r[0]) best = 2'd1;
    if (cr_r[2] <= cr_r[best]) best = 2'd2;
    tn          = (cr_r[best] < T_ONE) ? cr_r[best] : T_ONE;
    vm          = mem_q[31] ? 32'(-mem_q) : mem_q;
    acc_sum     = {1'b0, acc} + {1'b0, m_r};
  end

  assign q_ready = (state == S_IDLE);

  // voxel store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_valid && !q_item.is_query && q_item.wr_ok) begin
      mem[wr_addr] <= q_item.value;
    end
    if (state == S_CHECK) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready && state != S_DONE) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid && q_item.is_query) begin
            s_r[0]  <= q_item.sx;
            s_r[1]  <= q_item.sy;
            s_r[2]  <= q_item.sz;
            d_r[0]  <= 33'(q_item.ex) - 33'(q_item.sx);
            d_r[1]  <= 33'(q_item.ey) - 33'(q_item.sy);
            d_r[2]  <= 33'(q_item.ez) - 33'(q_item.sz);
            sp_r[0] <= (cfg.spacing_x == '0) ? 31'd1 : cfg.spacing_x;
            sp_r[1] <= (cfg.spacing_y == '0) ? 31'd1 : cfg.spacing_y;
            sp_r[2] <= (cfg.spacing_z == '0) ? 31'd1 : cfg.spacing_z;
            sq_sum  <= '0;
            ax      <= 2'd0;
            state   <= S_SQ;
          end
        end
        S_SQ: begin
          sq_sum <= sq_sum + 66'(dabs * dabs);
          if (ax == 2'd2) begin
            rrem  <= '0;
            root  <= '0;
            cnt   <= 6'd32;
            state <= S_ROOT;
          end else begin
            ax <= ax + 2'd1;
          end
        end
        S_ROOT: begin
          rrem   <= rt_ge ? (rt_rem2 - rt_trial) : rt_rem2;
          root   <= root_next;
          sq_sum <= {sq_sum[63:0], 2'b00};
          cnt    <= cnt - 6'd1;
          if (cnt == 6'd0) begin
            len_r <= root_next;
            ax    <= 2'd0;
            state <= S_RND;
          end
        end
        S_RND: begin
          // round to nearest: (2|s| + sp) / (2 sp)
          dv_rem <= '0;
          dv_d   <= rnd_num;
          dv_den <= {2'b00, sp_r[ax], 1'b0};
          dv_q   <= '0;
          cnt    <= 6'd33;
          state  <= S_RND_DIV;
        end
        S_RND_DIV: begin
          dv_rem <= dv_rem_next;
          dv_d   <= {dv_d[32:0], 1'b0};
          dv_q   <= dv_q_next;
          cnt    <= cnt - 6'd1;
          if (cnt == 6'd0) begin
            idx_r[ax] <= s_r[ax][31] ? -IDX_W'(dv_q_next) : IDX_W'(dv_q_next);
            if (ax == 2'd2) begin
              need  <= 3'b111;
              t_r   <= '0;
              acc   <= ACC_BIAS;
              sat   <= 1'b0;
              left  <= 1'b0;
              state <= S_CHECK;
            end else begin
              ax    <= ax + 2'd1;
              state <= S_RND;
            end
          end
        end
        S_CHECK: begin
          if (!in_grid) begin
            left  <= 1'b1;
            state <= S_DONE;
          end else begin
            ax    <= first_axis(need);
            state <= S_CX_MUL;
          end
        end
        S_CX_MUL: begin
          if (d_r[ax] == '0) begin
            cr_r[ax] <= T_FLAT;
            need     <= need_rest;
            ax       <= first_axis(need_rest);
            state    <= (need_rest == '0) ? S_PICK : S_CX_MUL;
          end else begin
            prod_r <= 44'(kmul * $signed({1'b0, sp_r[ax]}));
            state  <= S_CX_NUM;
          end
        end
        S_CX_NUM: begin
          if (num <= 0 || num >= $signed({11'b0, dabs, 1'b0})) begin
            cr_r[ax] <= (num <= 0) ? 34'd0 : T_ONE;
            need     <= need_rest;
            ax       <= first_axis(need_rest);
            state    <= (need_rest == '0) ? S_PICK : S_CX_MUL;
          end else begin
            dv_rem <= num[33:0];
            dv_d   <= '0;
            dv_den <= {dabs, 1'b0};
            dv_q   <= '0;
            cnt    <= 6'd31;
            state  <= S_CX_DIV;
          end
        end
        S_CX_DIV: begin
          dv_rem <= dv_rem_next;
          dv_q   <= dv_q_next;
          cnt    <= cnt - 6'd1;
          if (cnt == 6'd0) begin
            cr_r[ax] <= {2'b00, dv_q_next[31:0]};
            need     <= need_rest;
            ax       <= first_axis(need_rest);
            state    <= (need_rest == '0) ? S_PICK : S_CX_MUL;
          end
        end
        S_PICK: begin
          dt_r <= (tn > 34'(t_r)) ? 33'(tn - 34'(t_r)) : 33'd0;
          if (tn > 34'(t_r)) begin
            t_r <= 33'(tn);
          end
          ax    <= best;
          state <= S_MUL1;
        end
        S_MUL1: begin
          p1_r  <= 66'(dt_r * len_r);
          state <= S_MUL2;
        end
        S_MUL2: begin
          m_r   <= 64'(p1_r[65:32] * vm);
          v_neg <= mem_q[31];
          v_pos <= !mem_q[31] && (mem_q != '0);
          state <= S_ACC;
        end
        S_ACC: begin
          if (v_pos) begin
            if (acc_sum[64]) begin
              acc <= '1;
              sat <= 1'b1;
            end else begin
              acc <= acc_sum[63:0];
            end
          end else if (v_neg) begin
            if (m_r > acc) begin
              acc <= '0;
              sat <= 1'b1;
            end else begin
              acc <= acc - m_r;
            end
          end
          // advance the axis whose boundary came first
          if (d_r[ax][32]) begin
            idx_r[ax] <= idx_r[ax] - IDX_W'(1);
          end else if (d_r[ax] != '0) begin
            idx_r[ax] <= idx_r[ax] + IDX_W'(1);
          end
          need  <= 3'b001 << ax;
          state <= (34'(t_r) >= T_ONE) ? S_DONE : S_CHECK;
        end
        S_DONE: begin
          if (!res_valid || res_ready) begin
            res_valid    <= 1'b1;
            res_integral <= acc ^ ACC_BIAS;
            res_status   <= left ? STATUS_LEFT : (sat ? STATUS_SAT : STATUS_OK);
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: src/voxel_ray_line_integral.sv
// Top level of the voxel ray line integral block: config registers, front and walker.
//
// Line integral of a 3D voxel field along a segment. Words with tuser 0 write one
// Q16.16 voxel of a 32x32x32 store (writes outside the grid are dropped); words
// with tuser 1 give segment endpoints in Q16.16 and produce one result word: the
// Q32.32 integral on m_tdata and a status on m_tuser (0 ok, 1 ray left the grid,
// 2 saturated). Load every voxel a query can touch before querying; an unwritten
// voxel reads as garbage. A query first sets up the squared length, a bit-serial
// square root and three rounding divides, then for each voxel visited computes the
// axis crossings it needs on the one shared radix-2 divider (no divide on a flat
// axis): the first voxel needs all three axes, each later one only the axis just
// advanced. A four-word input queue lets words be taken while the walker is busy, and
// the result register lets the next query start while a result waits on m_tready.
// Configuration writes are always ready and must only be made while the block
// is idle.
module voxel_ray_line_integral
  import vrli_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  // plane[4:0] row[9:5] col[14:10] value[46:15] start_x[78:47] start_y[110:79]
  // start_z[142:111] end_x[174:143] end_y[206:175] end_z[238:207], pad [239]
  input  logic [TDATA_W-1:0] s_tdata,
  // cmd[0]
  input  logic               s_tuser,
  output logic               m_tvalid,
  input  logic               m_tready,
  // integral[63:0]
  output logic [63:0]        m_tdata,
  // status[1:0]
  output logic [1:0]         m_tuser,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data
);

  cfg_t  cfg;
  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  assign cfg_ready = 1'b1;

  // hold the register file; reset to unit spacing and a full row count
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.spacing_x <= 31'd65536;
      cfg.spacing_y <= 31'd65536;
      cfg.spacing_z <= 31'd65536;
      cfg.rows      <= 6'd32;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SPACING_X: cfg.spacing_x <= cfg_data;
        REG_SPACING_Y: cfg.spacing_y <= cfg_data;
        REG_SPACING_Z: cfg.spacing_z <= cfg_data;
        REG_ROWS:      cfg.rows      <= cfg_data[5:0];
        default:       ;
      endcase
    end
  end

  vrli_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  vrli_walk u_walk (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_item       (q_item),
    .res_valid    (m_tvalid),
    .res_ready    (m_tready),
    .res_integral (m_tdata),
    .res_status   (m_tuser)
  );

endmodule

FILE: tb/tb_voxel_ray_line_integral.sv
// Testbench for voxel_ray_line_integral: random and directed traffic checked against a predictor.
`timescale 1ns / 100ps

module tb_voxel_ray_line_integral
  import vrli_pkg::*;
();

  // One input word as the sender sees it.
  typedef struct {
    logic        cmd;
    logic [4:0]  plane;
    logic [4:0]  row;
    logic [4:0]  col;
    logic [31:0] value;
    logic [31:0] pt_a [3];   // segment start x, y, z
    logic [31:0] pt_b [3];   // segment end x, y, z
  } word_t;

  typedef struct {
    logic [63:0] integral;
    logic [1:0]  status;
    bit          unknown;   // walk touched a voxel that was never loaded
  } sum_t;

  // Scoreboard: mirror of the voxel store and registers, integral predictor,
  // and the queue of integrals still owed by the block.
  class integral_board;
    logic [31:0] voxels [STORE_DEPTH];
    bit          loaded [STORE_DEPTH];
    logic [30:0] spacing [3];
    logic [5:0]  rows;
    sum_t        owed [$];
    int          errors, shown, results, writes, queries;
    int          n_left, n_sat, n_skipped;

    function void reset_state();
      spacing = '{31'd65536, 31'd65536, 31'd65536};
      rows    = 6'd32;
    endfunction

    function void set_reg(logic [1:0] idx, logic [30:0] data);
      case (idx)
        REG_SPACING_X: spacing[0] = data;
        REG_SPACING_Y: spacing[1] = data;
        REG_SPACING_Z: spacing[2] = data;
        REG_ROWS:      rows = data[5:0];
        default: ;
      endcase
    endfunction

    // Parametric position of the next boundary crossing on one axis, Q0.32.
    function logic [33:0] crossing_t(longint vidx, int dir, longint sp, longint s, longint d);
      longint      num, den;
      logic [95:0] nn, q;
      if (dir == 0) return T_FLAT;
      if (dir > 0) begin
        num = (2 * vidx + 1) * sp - 2 * s;
        den = 2 * d;
      end else begin
        num = 2 * s - (2 * vidx - 1) * sp;
        den = -2 * d;
      end
      if (num <= 0) return 34'd0;
      if (num >= den) return T_ONE;
      nn = {num[63:0], 32'd0};
      q  = nn / 96'(den);
      return q[33:0];
    endfunction

    function sum_t integrate(word_t w);
      longint              s [3], d [3], vidx [3], sp [3];
      int                  dir [3];
      longint unsigned     mag, q;
      logic [65:0]         sq;
      logic [33:0]         len, c, cr [3], tn;
      logic [63:0]         t, dt, acc, piece, vm, m;
      logic [127:0]        pr;
      longint              row, v;
      int                  best, sv, addr;
      bit                  sat, left, unk;
      sum_t                r;
      sq = '0; t = '0; acc = ACC_BIAS; sat = 0; left = 0; unk = 0;
      for (int a = 0; a < 3; a++) begin
        s[a]   = longint'(signed'(w.pt_a[a]));
        d[a]   = longint'(signed'(w.pt_b[a])) - s[a];
        dir[a] = d[a] > 0 ? 1 : (d[a] < 0 ? -1 : 0);
        sp[a]  = spacing[a] == 0 ? 1 : longint'(spacing[a]);
        mag    = d[a] < 0 ? -d[a] : d[a];
        sq    += 66'(mag) * 66'(mag);
        mag    = s[a] < 0 ? -s[a] : s[a];
        q      = (2 * mag + sp[a]) / (2 * sp[a]);
        vidx[a] = s[a] < 0 ? -longint'(q) : longint'(q);
      end
      // floor square root, one result bit per pass
      len = '0;
      for (int b = 32; b >= 0; b--) begin
        c = len | (34'd1 << b);
        if (68'(c) * 68'(c) <= 68'(sq)) len = c;
      end
      while (t < 64'(T_ONE)) begin
        row = longint'(rows) - 1 - vidx[1];
        if (vidx[0] < 0 || vidx[0] >= GRID_COLS || row < 0 || row >= GRID_ROWS ||
            vidx[2] < 0 || vidx[2] >= GRID_PLANES) begin
          left = 1;
          break;
        end
        best = 0;
        for (int a = 0; a < 3; a++) begin
          cr[a] = crossing_t(vidx[a], dir[a], sp[a], s[a], d[a]);
          if (cr[a] <= cr[best]) best = a;   // ties go to the higher axis
        end
        tn = cr[best] < T_ONE ? cr[best] : T_ONE;
        dt = 64'(tn) > t ? 64'(tn) - t : 64'd0;
        if (64'(tn) > t) t = 64'(tn);
        pr    = 128'(dt) * 128'(len);
        piece = pr[95:32];
        addr  = int'((vidx[2] * GRID_ROWS + row) * GRID_COLS + vidx[0]);
        if (!loaded[addr]) unk = 1;
        sv    = voxels[addr];
        v     = sv;
        vm    = v < 0 ? -v : v;
        m     = piece * vm;
        if (v > 0) begin
          if (m > ~acc) begin acc = '1; sat = 1; end
          else acc += m;
        end else if (v < 0) begin
          if (m > acc) begin acc = '0; sat = 1; end
          else acc -= m;
        end
        vidx[best] += dir[best];
      end
      r.integral = acc ^ ACC_BIAS;
      r.status   = left ? STATUS_LEFT : (sat ? STATUS_SAT : STATUS_OK);
      r.unknown  = unk;
      return r;
    endfunction

    // Note an accepted input word: update the store or queue the expected integral.
    function void note_word(word_t w);
      int addr;
      if (w.cmd == CMD_WRITE) begin
        writes++;
        addr = (int'(w.plane) * GRID_ROWS + int'(w.row)) * GRID_COLS + int'(w.col);
        voxels[addr] = w.value;
        loaded[addr] = 1;
      end else begin
        queries++;
        owed.push_back(integrate(w));
      end
    endfunction

    function void check_result(logic [63:0] integral, logic [1:0] status);
      sum_t e;
      results++;
      if (status == STATUS_LEFT) n_left++;
      if (status == STATUS_SAT) n_sat++;
      if (owed.size() == 0) begin
        errors++;
        if (shown++ < 10) $display("unexpected result word: integral %h status %0d",
                                   integral, status);
        return;
      end
      e = owed.pop_front();
      // a walk over never-loaded voxels has no defined answer; keep order only
      if (e.unknown) begin
        n_skipped++;
        return;
      end
      if (e.integral !== integral || e.status !== status) begin
        errors++;
        if (shown++ < 10)
          $display("result %0d mismatch: integral exp %h got %h, status exp %0d got %0d",
                   results, e.integral, integral, e.status, status);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [TDATA_W-1:0] s_tdata = '0;
  logic               s_tuser = 1'b0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [63:0]        m_tdata;
  logic [1:0]         m_tuser;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [30:0]        cfg_data = '0;

  integral_board board = new();
  int unsigned   hold_left = 0;    // long receiver hold, counted down by the receiver
  int            burst_left = 0;
  int            mode = 0, mode_left = 0;
  int            settings = 1;

  voxel_ray_line_integral i_dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: switch at random among always, mostly and rarely ready patterns; honor a requested hold.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(50, 400);
      end
      mode_left--;
      case (mode)
        0:       m_tready <= 1'b1;
        1:       m_tready <= $urandom_range(0, 99) < 60;
        default: m_tready <= $urandom_range(0, 15) == 0;
      endcase
    end
  end

  // Sample result words at the rising edge.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata, m_tuser);
  end

  function automatic logic [31:0] clamp32(longint x);
    if (x > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (x < -64'sd2147483648) return 32'h8000_0000;
    return x[31:0];
  endfunction

  // Offer one word; called and returning at a falling edge. Insert burst gaps.
  task automatic send_word(word_t w);
    if (burst_left == 0) begin
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        if (s_tvalid) s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    s_tdata <= {1'b0, w.pt_b[2], w.pt_b[1], w.pt_b[0], w.pt_a[2], w.pt_a[1], w.pt_a[0],
                w.value, w.col, w.row, w.plane};
    s_tuser  <= w.cmd;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    board.note_word(w);
    @(negedge clk);
  endtask

  // Drop valid and hold until every expected integral is back and the queue drained.
  task automatic drain();
    if (s_tvalid) s_tvalid <= 1'b0;
    burst_left = 0;
    while (board.owed.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic write_regs(logic [30:0] sx, logic [30:0] sy, logic [30:0] sz, logic [5:0] rows);
    logic [30:0] vals [4];
    vals = '{sx, sy, sz, {25'd0, rows}};
    for (int i = 0; i < 4; i++) begin
      cfg_index <= i[1:0];
      cfg_data  <= vals[i];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      board.set_reg(i[1:0], vals[i]);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    settings++;
  endtask

  function automatic word_t voxel_word(int p, int r, int c, logic [31:0] val);
    word_t w;
    w.cmd = CMD_WRITE; w.plane = 5'(p); w.row = 5'(r); w.col = 5'(c); w.value = val;
    for (int a = 0; a < 3; a++) begin
      w.pt_a[a] = $urandom();
      w.pt_b[a] = $urandom();
    end
    return w;
  endfunction

  function automatic logic [31:0] random_value();
    int unsigned k;
    k = $urandom_range(0, 15);
    if (k == 0) return $urandom();
    if (k == 1) return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    return 32'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
  endfunction

  // Query in grid units: coordinates a and b are voxel numbers scaled by 256.
  function automatic word_t segment(int ax, int ay, int az, int bx, int by, int bz);
    word_t  w;
    longint sp;
    int     pa [3], pb [3];
    w = voxel_word(0, 0, 0, '0);
    w.cmd = CMD_QUERY;
    pa = '{ax, ay, az};
    pb = '{bx, by, bz};
    for (int a = 0; a < 3; a++) begin
      sp = board.spacing[a] == 0 ? 1 : board.spacing[a];
      w.pt_a[a] = clamp32(longint'(pa[a]) * sp / 256);
      w.pt_b[a] = clamp32(longint'(pb[a]) * sp / 256);
    end
    return w;
  endfunction

  // Queries mostly stay around the loaded corner of the grid (x, y, z in 0..7); some are noise.
  function automatic word_t random_query();
    word_t w;
    int    k, pa [3], pb [3];
    k = $urandom_range(0, 19);
    for (int a = 0; a < 3; a++) begin
      if (k == 1) begin
        // long run across the whole loaded corner
        pa[a] = $urandom_range(0, 256);
        pb[a] = $urandom_range(6 * 256, 8 * 256);
      end else begin
        pa[a] = $urandom_range(0, 11 * 256) - 2 * 256;
        pb[a] = ($urandom_range(0, 3) == 0) ? pa[a] : pa[a] + $urandom_range(0, 8 * 256) - 4 * 256;
      end
    end
    w = segment(pa[0], pa[1], pa[2], pb[0], pb[1], pb[2]);
    if (k == 0) begin
      // noise: endpoints anywhere in the 32-bit range
      for (int a = 0; a < 3; a++) begin
        w.pt_a[a] = $urandom();
        w.pt_b[a] = $urandom();
      end
    end
    return w;
  endfunction

  task automatic random_traffic(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 40)
        send_word(voxel_word($urandom_range(0, 7), $urandom_range(24, 31),
                             $urandom_range(0, 7), random_value()));
      else
        send_word(random_query());
    end
  endtask

  // Run limit.
  initial begin
    repeat (40_000_000) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    word_t w;
    board.reset_state();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Load the corner of the grid that the queries walk: planes 0..7, store rows
    // 24..31 (y 0..7 at 32 rows), columns 0..7.
    for (int p = 0; p < 8; p++)
      for (int r = 24; r < 32; r++)
        for (int c = 0; c < 8; c++)
          send_word(voxel_word(p, r, c, random_value()));

    // Directed queries at reset settings (unit spacing, 32 rows).
    send_word(segment(5 * 256, 5 * 256, 5 * 256, 5 * 256, 5 * 256, 5 * 256)); // zero length
    send_word(segment(51, 768, 768, 1715, 768, 768));                         // +x
    send_word(segment(1715, 768, 768, 51, 768, 768));                         // -x
    send_word(segment(768, 100, 768, 768, 2000, 768));                        // +y
    send_word(segment(768, 768, 2000, 768, 768, 100));                        // -z
    send_word(segment(0, 0, 0, 7 * 256, 7 * 256, 7 * 256));                   // corner ties
    send_word(segment(-3 * 256, 768, 768, 768, 768, 768));                    // starts outside
    send_word(segment(2 * 256, 1024, 1024, -6 * 256, 1024, 1024));            // exits midway
    w = random_query();
    for (int a = 0; a < 3; a++) begin
      w.pt_a[a] = 32'h8000_0000;
      w.pt_b[a] = 32'h7FFF_FFFF;
    end
    send_word(w);
    random_traffic(120);
    drain();

    // Widest spacing: two voxels per axis span the whole coordinate range.
    write_regs(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 6'd32);
    for (int k = 0; k < 2; k++) begin
      for (int p = 0; p < 2; p++)
        for (int r = 30; r < 32; r++)
          for (int c = 0; c < 2; c++)
            send_word(voxel_word(p, r, c, k == 0 ? 32'h7FFF_FFFF : 32'h8000_0000));
      w = random_query();
      for (int a = 0; a < 3; a++) begin
        w.pt_a[a] = 32'hC000_0002;
        w.pt_b[a] = 32'h7FFF_FFFF;
      end
      send_word(w);   // drives the sum past the signed range
    end
    random_traffic(80);
    drain();

    write_regs(31'd0, 31'd0, 31'd0, 6'd32);           // zero spacing acts as one LSB
    random_traffic(60);
    drain();
    write_regs(31'd32768, 31'd131072, 31'd81920, 6'd28);
    random_traffic(60);
    drain();
    write_regs(31'd65536, 31'd65536, 31'd65536, 6'd63); // flipped rows mostly off grid
    random_traffic(50);
    drain();
    write_regs(31'd98304, 31'd65536, 31'd49152, 6'd0);
    random_traffic(50);
    drain();

    // Back to unit spacing; hold the receiver off long enough to back up the input.
    write_regs(31'd65536, 31'd65536, 31'd65536, 6'd32);
    @(posedge clk);
    hold_left = 3000;
    @(negedge clk);
    random_traffic(90);
    drain();

    $display("covered %0d voxel writes and %0d queries over %0d register settings",
             board.writes, board.queries, settings);
    $display("results %0d: %0d left the grid, %0d saturated, %0d over unloaded voxels, %0d mismatches",
             board.results, board.n_left, board.n_sat, board.n_skipped, board.errors);
    if (board.errors == 0 && board.owed.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
